FILE: sv/matrix3_inverse_assert.svh
// Assertion macros used by matrix3_inverse.sv.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define M3I_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define M3I_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define M3I_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define M3I_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/m3inv_pkg.sv
`timescale 1ns / 1ps
package m3inv_pkg;
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int ADJ_W     = 64;
    localparam int DET_W     = 97;
    localparam int MAG_W     = 96;
    localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;
    localparam int HI_W      = NUM_W - 32;
    localparam int QBITS     = 32;
    localparam int DET_LAT   = 6;
    // det front end, lane setup, quotient stages, rounding, output register
    localparam int LAT       = DET_LAT + 1 + QBITS + 1 + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [ADJ_W-1:0]  adj_t;
    typedef logic [MAG_W-1:0]         mag_t;

    typedef struct packed {
        logic dneg;
        logic dzero;
        mag_t dmag;
    } det_info_t;
endpackage

FILE: sv/m3inv_det.sv
`timescale 1ns / 1ps
module m3inv_det (
    input  logic                 aclk,
    input  logic                 ce,
    input  m3inv_pkg::elem_t     elem [9],
    output m3inv_pkg::adj_t      adj_out [9],
    output m3inv_pkg::det_info_t det_out
);
    // product pairs per adjugate entry, row-major element indexes
    logic signed [63:0]        prod_a_reg [9];
    logic signed [63:0]        prod_b_reg [9];
    m3inv_pkg::elem_t          r0_p1_reg [3];
    m3inv_pkg::elem_t          r0_p2_reg [3];
    m3inv_pkg::adj_t           adj_p2_reg [9];
    m3inv_pkg::adj_t           adj_p3_reg [9];
    m3inv_pkg::adj_t           adj_p4_reg [9];
    m3inv_pkg::adj_t           adj_p5_reg [9];
    m3inv_pkg::adj_t           adj_p6_reg [9];
    logic signed [64:0]        plo_reg [3];
    logic signed [63:0]        phi_reg [3];
    logic [m3inv_pkg::DET_W-1:0] term_reg [3];
    logic [m3inv_pkg::DET_W-1:0] det_reg;
    m3inv_pkg::det_info_t      info_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_a_reg[0] <= elem[4] * elem[8]; prod_b_reg[0] <= elem[7] * elem[5];
            prod_a_reg[1] <= elem[2] * elem[7]; prod_b_reg[1] <= elem[8] * elem[1];
            prod_a_reg[2] <= elem[1] * elem[5]; prod_b_reg[2] <= elem[4] * elem[2];
            prod_a_reg[3] <= elem[5] * elem[6]; prod_b_reg[3] <= elem[8] * elem[3];
            prod_a_reg[4] <= elem[0] * elem[8]; prod_b_reg[4] <= elem[6] * elem[2];
            prod_a_reg[5] <= elem[2] * elem[3]; prod_b_reg[5] <= elem[5] * elem[0];
            prod_a_reg[6] <= elem[3] * elem[7]; prod_b_reg[6] <= elem[6] * elem[4];
            prod_a_reg[7] <= elem[1] * elem[6]; prod_b_reg[7] <= elem[7] * elem[0];
            prod_a_reg[8] <= elem[0] * elem[4]; prod_b_reg[8] <= elem[3] * elem[1];
            for (int i = 0; i < 3; i++) begin
                r0_p1_reg[i] <= elem[i];
                r0_p2_reg[i] <= r0_p1_reg[i];
            end
            for (int i = 0; i < 9; i++) begin
                adj_p2_reg[i] <= prod_a_reg[i] - prod_b_reg[i];
                adj_p3_reg[i] <= adj_p2_reg[i];
                adj_p4_reg[i] <= adj_p3_reg[i];
                adj_p5_reg[i] <= adj_p4_reg[i];
                adj_p6_reg[i] <= adj_p5_reg[i];
            end
            // first-row expansion: a0j times adjugate entry (j, 0), split in halves
            for (int j = 0; j < 3; j++) begin
                plo_reg[j] <= r0_p2_reg[j] * $signed({1'b0, adj_p2_reg[3*j][31:0]});
                phi_reg[j] <= r0_p2_reg[j] * $signed(adj_p2_reg[3*j][63:32]);
                term_reg[j] <= {phi_reg[j][63], phi_reg[j], 32'b0}
                             + {{32{plo_reg[j][64]}}, plo_reg[j]};
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            info_reg.dneg  <= det_reg[m3inv_pkg::DET_W-1];
            info_reg.dzero <= (det_reg == '0);
            info_reg.dmag  <= det_reg[m3inv_pkg::DET_W-1]
                            ? m3inv_pkg::MAG_W'(-det_reg)
                            : det_reg[m3inv_pkg::MAG_W-1:0];
        end
    end

    assign adj_out = adj_p6_reg;
    assign det_out = info_reg;
endmodule

FILE: sv/m3inv_div_lane.sv
`timescale 1ns / 1ps
module m3inv_div_lane (
    input  logic              aclk,
    input  logic              ce,
    input  m3inv_pkg::adj_t   adj,
    input  logic              dneg,
    input  m3inv_pkg::mag_t   dmag,
    input  m3inv_pkg::mag_t   d_stage [m3inv_pkg::QBITS+1],
    output logic [31:0]       value,
    output logic              sat
);
    localparam int QB = m3inv_pkg::QBITS;
    localparam int MW = m3inv_pkg::MAG_W;
    localparam int ADJ_MAG_W = m3inv_pkg::ADJ_W;

    m3inv_pkg::mag_t r_reg   [QB+1];
    logic [31:0]     lo_reg  [QB+1];
    logic [QB-1:0]   q_reg   [QB+1];
    logic            neg_reg [QB+1];
    logic            sat_reg [QB+1];
    logic [31:0]     value_reg;
    logic            sat_out_reg;

    logic [ADJ_MAG_W-1:0] mag;
    logic [m3inv_pkg::NUM_W-1:0] num;
    m3inv_pkg::mag_t             hi;
    logic                        over;

    always_comb begin
        mag  = adj[ADJ_MAG_W-1] ? ADJ_MAG_W'(-adj) : ADJ_MAG_W'(adj);
        num  = {mag, {(2 * m3inv_pkg::FRAC_BITS){1'b0}}};
        hi   = MW'(num[m3inv_pkg::NUM_W-1:32]);
        over = (hi >= dmag);
    end

    // setup: quotient of 2^32 or more saturates at once
    always_ff @(posedge aclk) begin
        if (ce) begin
            r_reg[0]   <= over ? '0 : hi;
            lo_reg[0]  <= num[31:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= adj[ADJ_MAG_W-1] ^ dneg;
            sat_reg[0] <= over;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [MW:0] trial;
        logic        ge;
        always_comb begin
            trial = {r_reg[k-1], lo_reg[k-1][31]};
            ge    = (trial >= {1'b0, d_stage[k-1]});
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                r_reg[k]   <= ge ? MW'(trial - {1'b0, d_stage[k-1]}) : MW'(trial);
                lo_reg[k]  <= {lo_reg[k-1][30:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    // round half away from zero, clamp, apply sign
    logic        rnd;
    logic [32:0] q_rnd;
    logic [32:0] limit;
    logic        clamp;
    logic [31:0] mag_v;
    always_comb begin
        rnd   = ({r_reg[QB], 1'b0} >= {1'b0, d_stage[QB]});
        q_rnd = {1'b0, q_reg[QB]} + {32'b0, rnd};
        limit = neg_reg[QB] ? 33'h080000000 : 33'h07fffffff;
        clamp = sat_reg[QB] || (q_rnd > limit);
        mag_v = clamp ? limit[31:0] : q_rnd[31:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            value_reg   <= neg_reg[QB] ? -mag_v : mag_v;
            sat_out_reg <= clamp;
        end
    end

    assign value = value_reg;
    assign sat   = sat_out_reg;
endmodule

FILE: sv/matrix3_inverse.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse, signed Q16.16 in and out. While the output is not
// stalled, one matrix is taken per clock and a full pipeline delivers one
// result per cycle. Nine lanes, one per inverse element, each a 32-stage
// restoring divider producing one quotient bit per stage, sit behind a
// six-stage front end that forms the adjugate and the exact
// 97-bit determinant. Results are rounded to nearest, ties away from zero, and
// clamped to 32 bits (saturated flags any clamp). A zero determinant yields an
// all-zero matrix with ok low. When the output stalls, the whole pipeline holds.
module matrix3_inverse (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each), lowest first
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // inv00 .. inv22 (32 bits each), ok, saturated, 6 zero pad bits
    output logic [295:0] m_tdata
);
    localparam int QB   = m3inv_pkg::QBITS;
    localparam int LAT  = m3inv_pkg::LAT;
    localparam int DLAT = m3inv_pkg::DET_LAT;

    logic ce;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    m3inv_pkg::elem_t     elem [9];
    m3inv_pkg::adj_t      adj  [9];
    m3inv_pkg::det_info_t det;

    m3inv_pkg::mag_t dpipe_reg [QB+1];
    logic            zpipe_reg [QB+2];
    logic [31:0]     lane_val  [9];
    logic [8:0]      lane_sat;
    logic [295:0]    tdata_reg;

    // advance everything unless a finished result is waiting
    assign ce       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;

    for (genvar i = 0; i < 9; i++) begin : g_unpack
        assign elem[i] = s_tdata[32*i +: 32];
    end

    m3inv_det u_det (
        .aclk    (aclk),
        .ce      (ce),
        .elem    (elem),
        .adj_out (adj),
        .det_out (det)
    );

    // share the divisor and singular flag along the lane stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            dpipe_reg[0] <= det.dmag;
            zpipe_reg[0] <= det.dzero;
            for (int k = 1; k <= QB; k++) begin
                dpipe_reg[k] <= dpipe_reg[k-1];
            end
            for (int k = 1; k <= QB + 1; k++) begin
                zpipe_reg[k] <= zpipe_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_lane
        m3inv_div_lane u_lane (
            .aclk    (aclk),
            .ce      (ce),
            .adj     (adj[i]),
            .dneg    (det.dneg),
            .dmag    (det.dmag),
            .d_stage (dpipe_reg),
            .value   (lane_val[i]),
            .sat     (lane_sat[i])
        );
    end

    // merge lanes: zero the matrix when singular
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 9; i++) begin
                tdata_reg[32*i +: 32] <= zpipe_reg[QB+1] ? 32'b0 : lane_val[i];
            end
            tdata_reg[288]     <= !zpipe_reg[QB+1];
            tdata_reg[289]     <= !zpipe_reg[QB+1] && (|lane_sat);
            tdata_reg[295:290] <= '0;
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (ce) begin
            vld_next = {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = tdata_reg;

`include "matrix3_inverse_assert.svh"

    `M3I_ASSERT_IMPL(a_singular_zero, aclk, aresetn, m_tvalid && !m_tdata[288], m_tdata[287:0] == '0 && !m_tdata[289])
    `M3I_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `M3I_ASSERT_IMPL(a_block_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `M3I_ASSERT_NEXT(a_front_valid_moves, aclk, aresetn, ce && vld_reg[DLAT-1], vld_reg[DLAT])
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  DRAIN_WAIT  = m3inv_pkg::LAT + 20;
    localparam int  N_RANDOM    = 1700;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [31:0] MAXV  = 32'h7fff_ffff;
    localparam logic [31:0] MINV  = 32'h8000_0000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each), lowest first
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // inv00 .. inv22 (32 bits each), ok, saturated, 6 zero pad bits
    logic [295:0] m_tdata;

    logic [287:0] pending_mats[$];
    logic [295:0] expected_inverses[$];
    int           cycle_count;
    int           mismatch_count;
    int           send_gap;
    int           recv_gap;
    logic         no_idle_phase;
    int           singular_seen;
    int           clamped_seen;
    int           result_count;

    matrix3_inverse i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Exact inverse: adjugate over determinant, rounded half away from zero, clamped.
    function automatic logic [295:0] invert_q16(input logic [287:0] mat);
        logic signed [127:0] e[9];
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic signed [127:0] a;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        q;
        logic [127:0]        r;
        logic [127:0]        lim;
        logic                dneg;
        logic                neg;
        logic                sat;
        logic [295:0]        res;
        for (int k = 0; k < 9; k++) begin
            e[k] = $signed(mat[32*k +: 32]);
        end
        adj[0] = e[4] * e[8] - e[7] * e[5];
        adj[1] = e[2] * e[7] - e[8] * e[1];
        adj[2] = e[1] * e[5] - e[4] * e[2];
        adj[3] = e[5] * e[6] - e[8] * e[3];
        adj[4] = e[0] * e[8] - e[6] * e[2];
        adj[5] = e[2] * e[3] - e[5] * e[0];
        adj[6] = e[3] * e[7] - e[6] * e[4];
        adj[7] = e[1] * e[6] - e[7] * e[0];
        adj[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        res = '0;
        if (det == 0) begin
            return res;
        end
        dneg = det < 0;
        dmag = dneg ? -det : det;
        sat  = 1'b0;
        for (int k = 0; k < 9; k++) begin
            a   = adj[k];
            neg = (a < 0) != dneg;
            num = (a < 0) ? -a : a;
            num = num << (2 * m3inv_pkg::FRAC_BITS);
            q   = num / dmag;
            r   = num % dmag;
            if ((r << 1) >= dmag) begin
                q = q + 1;
            end
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (q > lim) begin
                sat = 1'b1;
                q   = lim;
            end
            res[32*k +: 32] = neg ? -q[31:0] : q[31:0];
        end
        res[288] = 1'b1;
        res[289] = sat;
        return res;
    endfunction

    function automatic logic [287:0] pack_mat(input logic [31:0] m[9]);
        logic [287:0] v;
        for (int k = 0; k < 9; k++) begin
            v[32*k +: 32] = m[k];
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Value at the field extremes, zero, plus or minus one, or minus one lsb.
    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return 32'h0;
            3: return ONE_Q;
            4: return -ONE_Q;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Random matrix of one of several flavors, biased toward interesting determinants.
    function automatic logic [287:0] random_mat();
        logic [31:0] m[9];
        int          flavor;
        int          span;
        flavor = $urandom_range(0, 9);
        span   = $urandom_range(1, 4);
        for (int k = 0; k < 9; k++) begin
            case (flavor)
                0, 1: m[k] = $urandom;
                2, 3: m[k] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                4: m[k] = $signed($urandom_range(0, 32)) - 16;
                5: m[k] = ($urandom_range(0, 3) == 0) ? corner_value() : $urandom;
                default: m[k] = $signed($urandom_range(0, 1 << (10 + 4 * span)))
                                - (1 << (9 + 4 * span));
            endcase
        end
        if (flavor >= 2 && flavor <= 3) begin
            // strengthen the diagonal so most land well-conditioned
            m[0] += ONE_Q * 4;
            m[4] += ONE_Q * 4;
            m[8] += ONE_Q * 4;
        end
        if (flavor == 8) begin
            // make it singular: copy or zero a row, or a column
            case ($urandom_range(0, 2))
                0: for (int c = 0; c < 3; c++) m[6 + c] = m[c];
                1: for (int c = 0; c < 3; c++) m[3 + c] = 0;
                default: for (int rr = 0; rr < 3; rr++) m[3*rr + 2] = m[3*rr];
            endcase
        end
        return pack_mat(m);
    endfunction

    // Drive the input channel: record accepted items, then offer the next one.
    always @(posedge aclk) begin
        logic         next_valid;
        logic [287:0] next_data;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                expected_inverses.push_back(invert_q16(s_tdata));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0 && !no_idle_phase) begin
                    send_gap <= send_gap - 1;
                end else if (pending_mats.size() > 0) begin
                    next_valid = 1'b1;
                    next_data  = pending_mats.pop_front();
                    send_gap   <= pick_gap();
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // Check results against the oldest prediction and stall the output at random.
    always @(posedge aclk) begin
        logic [295:0] want;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_inverses.size() == 0) begin
                    $error("result with no matrix outstanding: %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    want = expected_inverses.pop_front();
                    result_count <= result_count + 1;
                    if (!want[288]) singular_seen <= singular_seen + 1;
                    if (want[289]) clamped_seen <= clamped_seen + 1;
                    for (int k = 0; k < 9; k++) begin
                        if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                            $error("inv%0d%0d expected %h got %h", k / 3, k % 3,
                                   want[32*k +: 32], m_tdata[32*k +: 32]);
                            errs = errs + 1;
                        end
                    end
                    if (m_tdata[288] !== want[288]) begin
                        $error("ok expected %b got %b", want[288], m_tdata[288]);
                        errs = errs + 1;
                    end
                    if (m_tdata[289] !== want[289]) begin
                        $error("saturated expected %b got %b", want[289], m_tdata[289]);
                        errs = errs + 1;
                    end
                end
                mismatch_count <= mismatch_count + errs;
            end
            if (recv_gap > 0 && !no_idle_phase) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    // Flip now and then into a stretch with no idling on either side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            no_idle_phase <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            no_idle_phase <= ~no_idle_phase;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [31:0] m[9];
        aresetn  = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b0;

        // identity, its negation, and a scaled identity
        m = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        pending_mats.push_back(pack_mat(m));
        m = '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q};
        pending_mats.push_back(pack_mat(m));
        m = '{ONE_Q * 3, 0, 0, 0, ONE_Q * 7, 0, 0, 0, ONE_Q * 2};
        pending_mats.push_back(pack_mat(m));
        // all-zero matrix: singular
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        pending_mats.push_back(pack_mat(m));
        // all ones: singular
        m = '{ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q};
        pending_mats.push_back(pack_mat(m));
        // extremes everywhere
        m = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};
        pending_mats.push_back(pack_mat(m));
        m = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
        pending_mats.push_back(pack_mat(m));
        m = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV};
        pending_mats.push_back(pack_mat(m));
        m = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};
        pending_mats.push_back(pack_mat(m));
        m = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, MAXV, MINV};
        pending_mats.push_back(pack_mat(m));
        m = '{MINV, MAXV, 0, MAXV, MINV, MAXV, 0, MAXV, MINV};
        pending_mats.push_back(pack_mat(m));
        // tiny elements: inverse clamps high and low
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        pending_mats.push_back(pack_mat(m));
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        pending_mats.push_back(pack_mat(m));
        m = '{1, 2, 0, 3, 4, 0, 0, 0, 1};
        pending_mats.push_back(pack_mat(m));
        // large powers of two with exact small inverses, and thirds
        m = '{ONE_Q << 15, 0, 0, 0, ONE_Q << 14, 0, 0, 0, -(ONE_Q << 15)};
        pending_mats.push_back(pack_mat(m));
        m = '{ONE_Q * 3, 0, 0, 0, -ONE_Q * 3, 0, 0, 0, 32'h0002_0000};
        pending_mats.push_back(pack_mat(m));
        // permutation and a general well-conditioned matrix
        m = '{0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0};
        pending_mats.push_back(pack_mat(m));
        m = '{ONE_Q * 2, -ONE_Q, 0, -ONE_Q, ONE_Q * 2, -ONE_Q, 0, -ONE_Q, ONE_Q * 2};
        pending_mats.push_back(pack_mat(m));
        // all bits toggled
        m = '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
              32'hffff_ffff, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'h0};
        pending_mats.push_back(pack_mat(m));

        for (int n = 0; n < N_RANDOM; n++) begin
            pending_mats.push_back(random_mat());
        end

        aresetn <= 1'b1;
        // wait for every item to be taken and every result to arrive
        while (pending_mats.size() > 0 || s_tvalid || expected_inverses.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Inverted %0d matrices: %0d singular, %0d with clamped elements.",
                 result_count, singular_seen, clamped_seen);
        if (mismatch_count == 0 && expected_inverses.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/m3inv_pkg.sv
sv/m3inv_det.sv
sv/m3inv_div_lane.sv
sv/matrix3_inverse.sv
dv/tb.sv
